// ===== rtl/tmp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the trapezoidal motion profile evaluator.
package tmp_pkg;

  localparam int TICK_W     = 32;
  localparam int OP_W       = 16;
  localparam int PH_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TICK_W-1:0] OFFSET_MS = 32'd20;

  localparam logic [TICK_W-1:0] START_TICK_RST = 32'd0;
  localparam logic [OP_W-1:0]   ACCEL_TIME_RST = 16'd1000;
  localparam logic [OP_W-1:0]   TOTAL_TIME_RST = 16'd4000;
  localparam logic [OP_W-1:0]   TOP_SPEED_RST  = 16'd6554;

  localparam int DIV_STEP_DEFAULT = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TICK = 2'd0,
    REG_ACCEL_TIME = 2'd1,
    REG_TOTAL_TIME = 2'd2,
    REG_TOP_SPEED  = 2'd3
  } reg_idx_t;

  typedef enum logic [PH_W-1:0] {
    PH_WAIT   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_DONE   = 3'd4,
    PH_BAD    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [OP_W-1:0] rem;
    logic [OP_W-1:0] num;
    logic [OP_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [TICK_W-1:0] elapsed;
    phase_t            phase;
    logic [OP_W-1:0]   x;
    logic [OP_W:0]     y;
    logic [TICK_W-1:0] base;
    div_t              dv;
    logic [OP_W-1:0]   q1;
    logic [TICK_W-1:0] xq1;
    logic [TICK_W-1:0] n;
    logic              up;
    logic [OP_W-1:0]   speed;
    logic [TICK_W-1:0] distance;
  } pipe_t;

endpackage

// ===== rtl/tmp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tick samples and profile results.
interface tmp_sample_if;
  logic                         valid;
  logic                         ready;
  logic [tmp_pkg::TICK_W-1:0]   tick_now;

  modport source (output valid, output tick_now, input ready);
  modport sink   (input valid, input tick_now, output ready);
endinterface

interface tmp_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [tmp_pkg::TICK_W-1:0] elapsed_ms;
  logic [tmp_pkg::OP_W-1:0]          speed;
  logic [tmp_pkg::TICK_W-1:0]        distance;
  logic [tmp_pkg::PH_W-1:0]          phase;

  modport source (output valid, output elapsed_ms, output speed, output distance,
                  output phase, input ready);
  modport sink   (input valid, input elapsed_ms, input speed, input distance,
                  input phase, output ready);
endinterface

// ===== rtl/tmp_div_stage.sv =====
`timescale 1ns / 1ps
// Restoring division slice: STEPS quotient bits of a 32 by 16 bit division.
module tmp_div_stage #(
  parameter int STEPS = tmp_pkg::DIV_STEP_DEFAULT
) (
  input  tmp_pkg::div_t                d_in,
  input  logic [tmp_pkg::OP_W-1:0]     divisor,
  output tmp_pkg::div_t                d_out
);

  always_comb begin : div_steps
    tmp_pkg::div_t           d;
    logic [tmp_pkg::OP_W:0]  t;
    logic [tmp_pkg::OP_W:0]  diff;
    logic                    ge;
    d = d_in;
    for (int i = 0; i < STEPS; i++) begin
      t     = {d.rem, d.num[tmp_pkg::OP_W-1]};
      d.num = {d.num[tmp_pkg::OP_W-2:0], 1'b0};
      diff  = t - {1'b0, divisor};
      ge    = (t >= {1'b0, divisor});
      if (ge) begin
        d.rem = diff[tmp_pkg::OP_W-1:0];
      end else begin
        d.rem = t[tmp_pkg::OP_W-1:0];
      end
      d.quo = {d.quo[tmp_pkg::OP_W-2:0], ge};
    end
    d_out = d;
  end

endmodule

// ===== rtl/trapezoidal_motion_profile.sv =====
`timescale 1ns / 1ps
// Trapezoidal velocity profile evaluator: top level with its pipeline.
//
// The sample channel carries a millisecond tick; for each transfer the result
// channel returns one item: signed elapsed time (tick - start - 20 ms), speed,
// distance travelled and the phase code of the move.
// Four registers (start tick, ramp time, total time, top speed) are written
// through cfg_we / cfg_index / cfg_data; the user must write them only while
// no sample is in flight, which the block itself does not enforce.
// The evaluator is a pipeline of 6 + 2 * (16 / DIV_STEP) register stages,
// 14 with the default. One sample is taken per cycle while the result side
// takes its items. The stage count is set by the two restoring dividers by
// the ramp time, each resolving DIV_STEP quotient bits per stage. When the
// receiver stalls while the output stage holds a result, all stages hold
// and the sample side drops ready; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults: start 0,
// ramp 1000 ms, total 4000 ms, top speed 6554.
module trapezoidal_motion_profile #(
  parameter int DIV_STEP = tmp_pkg::DIV_STEP_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmp_pkg::CFG_DATA_W-1:0]     cfg_data,
  tmp_sample_if.sink                         sample,
  tmp_result_if.source                       result
);

  localparam int OW         = tmp_pkg::OP_W;
  localparam int TW         = tmp_pkg::TICK_W;
  localparam int DIV_STAGES = tmp_pkg::OP_W / DIV_STEP;
  localparam int S_IN       = 0;
  localparam int S_CLS      = 1;
  localparam int S_MUL      = 2;
  localparam int S_D1       = 3;
  localparam int S_MID      = S_D1 + DIV_STAGES;
  localparam int S_D2       = S_MID + 1;
  localparam int S_SUM      = S_D2 + DIV_STAGES;
  localparam int S_OUT      = S_SUM + 1;
  localparam int NSTAGE     = S_OUT + 1;

  logic [TW-1:0] start_tick;
  logic [OW-1:0] accel_time;
  logic [OW-1:0] total_time;
  logic [OW-1:0] top_speed;

  tmp_pkg::pipe_t pipe [NSTAGE];
  tmp_pkg::pipe_t nxt  [NSTAGE];
  logic [NSTAGE-1:0] vld;
  logic adv;

  logic          bad_cfg;
  logic [OW-1:0] tma;

  tmp_pkg::pipe_t in_nxt, cls_nxt, mul_nxt, mid_nxt, sum_nxt, out_nxt;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_tick <= tmp_pkg::START_TICK_RST;
      accel_time <= tmp_pkg::ACCEL_TIME_RST;
      total_time <= tmp_pkg::TOTAL_TIME_RST;
      top_speed  <= tmp_pkg::TOP_SPEED_RST;
    end else if (cfg_we) begin
      unique case (tmp_pkg::reg_idx_t'(cfg_index))
        tmp_pkg::REG_START_TICK: start_tick <= cfg_data[TW-1:0];
        tmp_pkg::REG_ACCEL_TIME: accel_time <= cfg_data[OW-1:0];
        tmp_pkg::REG_TOTAL_TIME: total_time <= cfg_data[OW-1:0];
        tmp_pkg::REG_TOP_SPEED:  top_speed  <= cfg_data[OW-1:0];
        default: ;
      endcase
    end
  end

  assign bad_cfg = (accel_time == '0) || ({1'b0, total_time} < {accel_time, 1'b0});
  assign tma     = total_time - accel_time;

  assign adv          = !vld[S_OUT] || result.ready;
  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], sample.valid};
    end
  end

  always_comb begin
    in_nxt         = '0;
    in_nxt.elapsed = sample.tick_now - start_tick - tmp_pkg::OFFSET_MS;
  end

  always_comb begin : classify
    logic [TW-1:0] e;
    e       = pipe[S_IN].elapsed;
    cls_nxt = pipe[S_IN];
    cls_nxt.x = '0;
    cls_nxt.y = {1'b0, tma};
    priority if (bad_cfg) begin
      cls_nxt.phase = tmp_pkg::PH_BAD;
    end else if (e[TW-1]) begin
      cls_nxt.phase = tmp_pkg::PH_WAIT;
    end else if (e <= {{(TW-OW){1'b0}}, accel_time}) begin
      cls_nxt.phase = tmp_pkg::PH_ACCEL;
      cls_nxt.x     = e[OW-1:0];
    end else if (e <= {{(TW-OW){1'b0}}, tma}) begin
      cls_nxt.phase = tmp_pkg::PH_CRUISE;
      cls_nxt.y     = {e[OW-1:0], 1'b0} - {1'b0, accel_time};
    end else if (e <= {{(TW-OW){1'b0}}, total_time}) begin
      cls_nxt.phase = tmp_pkg::PH_DECEL;
      cls_nxt.x     = total_time - e[OW-1:0];
    end else begin
      cls_nxt.phase = tmp_pkg::PH_DONE;
    end
  end

  always_comb begin : mult_a
    logic [TW-1:0] prod_a;
    logic [TW:0]   prod_b;
    prod_a  = {{(TW-OW){1'b0}}, top_speed} * {{(TW-OW){1'b0}}, pipe[S_CLS].x};
    prod_b  = {{(TW-OW+1){1'b0}}, top_speed} * {{(TW-OW){1'b0}}, pipe[S_CLS].y};
    mul_nxt = pipe[S_CLS];
    mul_nxt.dv.rem = prod_a[TW-1:OW];
    mul_nxt.dv.num = prod_a[OW-1:0];
    mul_nxt.dv.quo = '0;
    if (pipe[S_CLS].phase == tmp_pkg::PH_CRUISE) begin
      mul_nxt.base = prod_b[TW:1];
    end else begin
      mul_nxt.base = prod_b[TW-1:0];
    end
  end

  always_comb begin : mult_b
    logic [TW-1:0] prod_r;
    logic [TW-1:0] prod_q;
    prod_r  = {{(TW-OW){1'b0}}, pipe[S_MID-1].x} * {{(TW-OW){1'b0}}, pipe[S_MID-1].dv.rem};
    prod_q  = {{(TW-OW){1'b0}}, pipe[S_MID-1].x} * {{(TW-OW){1'b0}}, pipe[S_MID-1].dv.quo};
    mid_nxt = pipe[S_MID-1];
    mid_nxt.q1     = pipe[S_MID-1].dv.quo;
    mid_nxt.xq1    = prod_q;
    mid_nxt.dv.rem = prod_r[TW-1:OW];
    mid_nxt.dv.num = prod_r[OW-1:0];
    mid_nxt.dv.quo = '0;
  end

  always_comb begin
    sum_nxt    = pipe[S_SUM-1];
    sum_nxt.n  = pipe[S_SUM-1].xq1 + {{(TW-OW){1'b0}}, pipe[S_SUM-1].dv.quo};
    sum_nxt.up = (pipe[S_SUM-1].dv.rem != '0);
  end

  always_comb begin : finish
    logic [TW-1:0] half;
    logic [TW-1:0] ceil_half;
    half      = {1'b0, pipe[S_SUM].n[TW-1:1]};
    ceil_half = half + {{(TW-1){1'b0}}, pipe[S_SUM].n[0] | pipe[S_SUM].up};
    out_nxt   = pipe[S_SUM];
    unique case (pipe[S_SUM].phase)
      tmp_pkg::PH_ACCEL: begin
        out_nxt.speed    = pipe[S_SUM].q1;
        out_nxt.distance = half;
      end
      tmp_pkg::PH_CRUISE: begin
        out_nxt.speed    = top_speed;
        out_nxt.distance = pipe[S_SUM].base;
      end
      tmp_pkg::PH_DECEL: begin
        out_nxt.speed    = pipe[S_SUM].q1;
        out_nxt.distance = pipe[S_SUM].base - ceil_half;
      end
      tmp_pkg::PH_DONE: begin
        out_nxt.speed    = '0;
        out_nxt.distance = pipe[S_SUM].base;
      end
      default: begin
        out_nxt.speed    = '0;
        out_nxt.distance = '0;
      end
    endcase
  end

  assign nxt[S_IN]  = in_nxt;
  assign nxt[S_CLS] = cls_nxt;
  assign nxt[S_MUL] = mul_nxt;
  assign nxt[S_MID] = mid_nxt;
  assign nxt[S_SUM] = sum_nxt;
  assign nxt[S_OUT] = out_nxt;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tmp_pkg::div_t  q1_dv, q2_dv;
    tmp_pkg::pipe_t stg1, stg2;

    tmp_div_stage #(.STEPS(DIV_STEP)) u_div1 (
      .d_in    (pipe[S_D1+g-1].dv),
      .divisor (accel_time),
      .d_out   (q1_dv)
    );

    tmp_div_stage #(.STEPS(DIV_STEP)) u_div2 (
      .d_in    (pipe[S_D2+g-1].dv),
      .divisor (accel_time),
      .d_out   (q2_dv)
    );

    always_comb begin
      stg1    = pipe[S_D1+g-1];
      stg1.dv = q1_dv;
      stg2    = pipe[S_D2+g-1];
      stg2.dv = q2_dv;
    end

    assign nxt[S_D1+g] = stg1;
    assign nxt[S_D2+g] = stg2;
  end

  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  assign result.valid      = vld[S_OUT];
  assign result.elapsed_ms = signed'(pipe[S_OUT].elapsed);
  assign result.speed      = pipe[S_OUT].speed;
  assign result.distance   = pipe[S_OUT].distance;
  assign result.phase      = pipe[S_OUT].phase;

endmodule
